/* rtl/kmnc_pkg.sv */
// ============================================================================
// kmnc_pkg: shared definitions for the nearest-centroid classifier
// Sizes, field widths, codes and the small types that several files use.
// ============================================================================
`default_nettype none

package kmnc_pkg;

    // Table size.
    localparam int MAX_CLUSTERS = 16;
    localparam int MAX_DIMS     = 4;
    localparam int NUM_COORDS   = 4;

    // Field widths fixed by the interface.
    localparam int COORD_W    = 24;
    localparam int SLOT_W     = 4;
    localparam int OUT_IDX_W  = 4;
    localparam int DIST_W     = 64;
    localparam int CLUSTERS_W = 5;
    localparam int DIMS_W     = 3;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    // Point scaling: a 24-bit coordinate times 100 fits in 31 bits.
    localparam int SCALE = 100;
    localparam int PT_W  = COORD_W + 7;
    localparam int SQ_W  = 2 * PT_W;

    // Derived counter and index widths.
    localparam int CIDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int CNT_W  = $clog2(MAX_CLUSTERS + 1);
    localparam int DCNT_W = $clog2(MAX_DIMS + 1);
    localparam int PAIRS  = (MAX_DIMS + 1) / 2;

    // Center vector as stored in memory, one row per cluster.
    localparam int ROW_W = MAX_DIMS * COORD_W;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [PT_W-1:0]    pt_t;
    typedef logic [SQ_W-1:0]    sq_t;
    typedef logic [DIST_W-1:0]  dist_t;
    typedef logic [CIDX_W-1:0]  cidx_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [DCNT_W-1:0]  dcnt_t;
    typedef logic [ROW_W-1:0]   row_t;

    typedef pt_t [MAX_DIMS-1:0] point_t;

    // Action codes.
    localparam logic ACT_LOAD     = 1'b0;
    localparam logic ACT_CLASSIFY = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_CLUSTERS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_DIMS     = 1'b1;

    // Marker that travels with each center through the distance pipeline.
    typedef struct packed {
        logic  valid;
        logic  last;
        cidx_t idx;
    } tag_t;

endpackage

`default_nettype wire

/* rtl/kmeans_nearest_centroid_top.sv */
// ============================================================================
// kmeans_nearest_centroid_top: nearest-centroid classifier
// A load beat writes one whole center row in one write. A classify beat
// scans the center memory one row per cycle and returns the nearest center.
// ============================================================================
// A classify beat scans the cluster count clamped to 1..16. Its result is
// registered once the scan, the distance pipeline and the argmin have finished
// and the result register is free; only then is the next beat taken.
// A load returns nothing.
// Reset clears the control state and sets clusters_in_use and dims_in_use to
// 2; the center memory holds nothing valid until loaded.
`default_nettype none

module kmeans_nearest_centroid_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Configuration write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [kmnc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [kmnc_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Input channel
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_action,
    input  wire logic [kmnc_pkg::SLOT_W-1:0]         s_center_slot,
    input  wire logic [kmnc_pkg::COORD_W-1:0]        s_coord_0,
    input  wire logic [kmnc_pkg::COORD_W-1:0]        s_coord_1,
    input  wire logic [kmnc_pkg::COORD_W-1:0]        s_coord_2,
    input  wire logic [kmnc_pkg::COORD_W-1:0]        s_coord_3,
    // Result channel
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [kmnc_pkg::OUT_IDX_W-1:0]      m_nearest_cluster,
    output logic      [kmnc_pkg::DIST_W-1:0]         m_min_distance
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    logic [kmnc_pkg::CLUSTERS_W-1:0] clusters_reg;
    logic [kmnc_pkg::DIMS_W-1:0]     dims_reg;

    kmnc_pkg::cnt_t   nc_reg, nc_next;
    kmnc_pkg::dcnt_t  nd_reg, nd_next;
    kmnc_pkg::cnt_t   cnt_reg, cnt_next;
    kmnc_pkg::point_t point_reg, point_next;

    logic                            m_valid_reg, m_valid_next;
    logic [kmnc_pkg::OUT_IDX_W-1:0]  m_idx_reg, m_idx_next;
    kmnc_pkg::dist_t                 m_dist_reg, m_dist_next;

    logic             in_fire;
    logic             load_fire;
    logic             classify_fire;
    logic             out_free;
    logic             ram_we;
    kmnc_pkg::row_t   ram_wdata;
    kmnc_pkg::row_t   ram_rdata;
    kmnc_pkg::coord_t coord_in [kmnc_pkg::NUM_COORDS];

    kmnc_pkg::tag_t   tag_issue;
    kmnc_pkg::tag_t   tag_rd_reg;
    kmnc_pkg::tag_t   tag_dist;
    kmnc_pkg::dist_t  dist_val;
    kmnc_pkg::dist_t  best_dist;
    kmnc_pkg::cidx_t  best_idx;
    logic             am_done;

    // Handshakes.
    assign cfg_ready     = 1'b1;
    assign s_ready       = (state_reg == ST_IDLE);
    assign in_fire       = s_valid && s_ready;
    assign load_fire     = in_fire && (s_action == kmnc_pkg::ACT_LOAD);
    assign classify_fire = in_fire && (s_action == kmnc_pkg::ACT_CLASSIFY);
    assign out_free      = !m_valid_reg || m_ready;

    assign coord_in[0] = s_coord_0;
    assign coord_in[1] = s_coord_1;
    assign coord_in[2] = s_coord_2;
    assign coord_in[3] = s_coord_3;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clusters_reg <= kmnc_pkg::CLUSTERS_W'(2);
            dims_reg     <= kmnc_pkg::DIMS_W'(2);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                kmnc_pkg::CFG_IDX_CLUSTERS: clusters_reg <= cfg_data[kmnc_pkg::CLUSTERS_W-1:0];
                kmnc_pkg::CFG_IDX_DIMS:     dims_reg     <= cfg_data[kmnc_pkg::DIMS_W-1:0];
                default:                    clusters_reg <= clusters_reg;
            endcase
        end
    end

    // Load path: the whole center row goes into memory in one write.
    always_comb begin
        for (int d = 0; d < kmnc_pkg::MAX_DIMS; d++) begin
            if (d < kmnc_pkg::NUM_COORDS) begin
                ram_wdata[d*kmnc_pkg::COORD_W +: kmnc_pkg::COORD_W] = coord_in[d];
            end else begin
                ram_wdata[d*kmnc_pkg::COORD_W +: kmnc_pkg::COORD_W] = '0;
            end
        end
    end

    assign ram_we = load_fire && (32'(s_center_slot) < 32'(kmnc_pkg::MAX_CLUSTERS));

    // Classify capture: scaled point and clamped counts.
    always_comb begin
        for (int d = 0; d < kmnc_pkg::MAX_DIMS; d++) begin
            if (d < kmnc_pkg::NUM_COORDS) begin
                point_next[d] = kmnc_pkg::pt_t'(coord_in[d])
                              * kmnc_pkg::pt_t'(kmnc_pkg::SCALE);
            end else begin
                point_next[d] = '0;
            end
        end
        if (clusters_reg == '0) begin
            nc_next = kmnc_pkg::cnt_t'(1);
        end else if (32'(clusters_reg) > 32'(kmnc_pkg::MAX_CLUSTERS)) begin
            nc_next = kmnc_pkg::cnt_t'(kmnc_pkg::MAX_CLUSTERS);
        end else begin
            nc_next = kmnc_pkg::cnt_t'(clusters_reg);
        end
        if (dims_reg == '0) begin
            nd_next = kmnc_pkg::dcnt_t'(1);
        end else if (32'(dims_reg) > 32'(kmnc_pkg::MAX_DIMS)) begin
            nd_next = kmnc_pkg::dcnt_t'(kmnc_pkg::MAX_DIMS);
        end else begin
            nd_next = kmnc_pkg::dcnt_t'(dims_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (classify_fire) begin
            point_reg <= point_next;
            nc_reg    <= nc_next;
            nd_reg    <= nd_next;
        end
    end

    // Read issue: one center row per cycle while scanning.
    always_comb begin
        tag_issue.valid = (state_reg == ST_SCAN);
        tag_issue.last  = (cnt_reg == nc_reg - kmnc_pkg::cnt_t'(1));
        tag_issue.idx   = cnt_reg[kmnc_pkg::CIDX_W-1:0];
    end

    kmnc_ram #(
        .WIDTH (kmnc_pkg::ROW_W),
        .DEPTH (kmnc_pkg::MAX_CLUSTERS)
    ) u_center_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (kmnc_pkg::cidx_t'(s_center_slot)),
        .wdata (ram_wdata),
        .raddr (cnt_reg[kmnc_pkg::CIDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // Tag lines up with the registered read data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_rd_reg <= '0;
        end else begin
            tag_rd_reg <= tag_issue;
        end
    end

    kmnc_dist u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tag_in   (tag_rd_reg),
        .row_in   (ram_rdata),
        .point    (point_reg),
        .dims     (nd_reg),
        .tag_out  (tag_dist),
        .dist_out (dist_val)
    );

    kmnc_argmin u_argmin (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (classify_fire),
        .tag_in    (tag_dist),
        .dist_in   (dist_val),
        .best_dist (best_dist),
        .best_idx  (best_idx),
        .done      (am_done)
    );

    // Sequencer and output register next-state logic.
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_idx_next   = m_idx_reg;
        m_dist_next  = m_dist_reg;
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (classify_fire) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + kmnc_pkg::cnt_t'(1);
                if (tag_issue.last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (am_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_idx_next   = kmnc_pkg::OUT_IDX_W'(best_idx);
                    m_dist_next  = best_dist;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        m_idx_reg  <= m_idx_next;
        m_dist_reg <= m_dist_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_nearest_cluster = m_idx_reg;
    assign m_min_distance    = m_dist_reg;

    // The center memory is never written while a scan reads it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_IDLE))
        else $error("center write during a scan");

    // The last center leaves the pipeline only after issue has stopped.
    assert property (@(posedge aclk) disable iff (!aresetn)
        am_done |-> (state_reg == ST_DRAIN))
        else $error("argmin completion outside drain");

    // Every center that reaches the distance pipeline is within the count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        tag_rd_reg.valid |-> (kmnc_pkg::cnt_t'(tag_rd_reg.idx) < nc_reg))
        else $error("center index beyond clusters in use");

    // A result beat appears only from the finish step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish");

endmodule

`default_nettype wire

/* rtl/kmnc_ram.sv */
// ============================================================================
// kmnc_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ============================================================================
`default_nettype none

module kmnc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                         aclk,
    input  wire logic                                         we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                             wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/kmnc_dist.sv */
// ============================================================================
// kmnc_dist: squared-distance pipeline
// Takes one center row per cycle and produces its squared distance to the
// held point after four register stages: absolute difference, square,
// pair sums, total.
// ============================================================================
`default_nettype none

module kmnc_dist (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire kmnc_pkg::tag_t    tag_in,
    input  wire kmnc_pkg::row_t    row_in,
    input  wire kmnc_pkg::point_t  point,
    input  wire kmnc_pkg::dcnt_t   dims,
    output kmnc_pkg::tag_t         tag_out,
    output kmnc_pkg::dist_t        dist_out
);

    kmnc_pkg::tag_t tag_s1_reg, tag_s2_reg, tag_s3_reg, tag_s4_reg;
    kmnc_pkg::pt_t   diff_next [kmnc_pkg::MAX_DIMS];
    kmnc_pkg::pt_t   diff_reg  [kmnc_pkg::MAX_DIMS];
    kmnc_pkg::sq_t   sq_reg    [kmnc_pkg::MAX_DIMS];
    kmnc_pkg::dist_t pair_next [kmnc_pkg::PAIRS];
    kmnc_pkg::dist_t pair_reg  [kmnc_pkg::PAIRS];
    kmnc_pkg::dist_t total_next;
    kmnc_pkg::dist_t total_reg;

    // Stage 1: absolute difference per dimension; unused dimensions are zero.
    always_comb begin
        kmnc_pkg::pt_t q;
        for (int d = 0; d < kmnc_pkg::MAX_DIMS; d++) begin
            q = kmnc_pkg::pt_t'(row_in[d*kmnc_pkg::COORD_W +: kmnc_pkg::COORD_W]);
            if (32'(d) >= 32'(dims)) begin
                diff_next[d] = '0;
            end else if (point[d] > q) begin
                diff_next[d] = point[d] - q;
            end else begin
                diff_next[d] = q - point[d];
            end
        end
    end

    // Stage 3 input: sums of neighboring squares.
    always_comb begin
        for (int k = 0; k < kmnc_pkg::PAIRS; k++) begin
            if (2 * k + 1 < kmnc_pkg::MAX_DIMS) begin
                pair_next[k] = kmnc_pkg::dist_t'(sq_reg[2*k])
                             + kmnc_pkg::dist_t'(sq_reg[2*k+1]);
            end else begin
                pair_next[k] = kmnc_pkg::dist_t'(sq_reg[2*k]);
            end
        end
    end

    // Stage 4 input: total over the pair sums, wrapping at 64 bits.
    always_comb begin
        total_next = '0;
        for (int k = 0; k < kmnc_pkg::PAIRS; k++) begin
            total_next = total_next + pair_reg[k];
        end
    end

    // Data stages.
    always_ff @(posedge aclk) begin
        for (int d = 0; d < kmnc_pkg::MAX_DIMS; d++) begin
            diff_reg[d] <= diff_next[d];
            sq_reg[d]   <= kmnc_pkg::sq_t'(diff_reg[d]) * kmnc_pkg::sq_t'(diff_reg[d]);
        end
        for (int k = 0; k < kmnc_pkg::PAIRS; k++) begin
            pair_reg[k] <= pair_next[k];
        end
        total_reg <= total_next;
    end

    // Tags ride alongside the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_s1_reg <= '0;
            tag_s2_reg <= '0;
            tag_s3_reg <= '0;
            tag_s4_reg <= '0;
        end else begin
            tag_s1_reg <= tag_in;
            tag_s2_reg <= tag_s1_reg;
            tag_s3_reg <= tag_s2_reg;
            tag_s4_reg <= tag_s3_reg;
        end
    end

    assign tag_out  = tag_s4_reg;
    assign dist_out = total_reg;

endmodule

`default_nettype wire

/* rtl/kmnc_argmin.sv */
// ============================================================================
// kmnc_argmin: running minimum over centers
// Keeps the smallest distance seen so far and its index; a later center with
// an equal distance takes over. Flags the cycle after the last center.
// ============================================================================
`default_nettype none

module kmnc_argmin (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire kmnc_pkg::tag_t   tag_in,
    input  wire kmnc_pkg::dist_t  dist_in,
    output kmnc_pkg::dist_t       best_dist,
    output kmnc_pkg::cidx_t       best_idx,
    output logic                  done
);

    kmnc_pkg::dist_t best_dist_reg;
    kmnc_pkg::cidx_t best_idx_reg;
    logic            done_reg;

    // Minimum and index, restarted at all ones for each point.
    always_ff @(posedge aclk) begin
        if (start) begin
            best_dist_reg <= '1;
            best_idx_reg  <= '0;
        end else if (tag_in.valid && !(dist_in > best_dist_reg)) begin
            best_dist_reg <= dist_in;
            best_idx_reg  <= tag_in.idx;
        end
    end

    // Completion flag after the last center is folded in.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= tag_in.valid && tag_in.last;
        end
    end

    assign best_dist = best_dist_reg;
    assign best_idx  = best_idx_reg;
    assign done      = done_reg;

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// ============================================================================
// tb: self-checking bench for the nearest-centroid classifier
// Loads center rows, programs the cluster and dimension counts, and sends
// points to classify. A behavioral model inside the bench tracks the center
// table and both counts and predicts the nearest center and its distance for
// every point. Each result beat is checked against that prediction. Both
// channels idle at random, and the result channel is held off once for a long
// stretch so that the block backs up into its input.
// ============================================================================

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kmnc_pkg::*;

    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = MAX_CLUSTERS + 16;
    localparam int STALL_LIMIT     = 4000;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int MAX_REPORTS     = 200;
    localparam coord_t COORD_MAX   = '1;

    // One input beat as the bench sees it.
    typedef struct packed {
        logic                          action;
        logic [SLOT_W-1:0]             slot;
        coord_t [NUM_COORDS-1:0]       crd;
    } centroid_beat_t;

    // One predicted result beat.
    typedef struct packed {
        logic [OUT_IDX_W-1:0] idx;
        dist_t                sqdist;
    } nearest_t;

    typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

    // Row of the directed stimulus list.
    typedef struct {
        row_kind_t               kind;
        centroid_beat_t          beat;
        logic [CFG_INDEX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0]   reg_val;
        bit                      fixed;
        nearest_t                answer;
    } stim_row_t;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_action;
    logic [SLOT_W-1:0]       s_center_slot;
    coord_t                  s_coord_0;
    coord_t                  s_coord_1;
    coord_t                  s_coord_2;
    coord_t                  s_coord_3;
    logic                    m_valid;
    logic                    m_ready;
    logic [OUT_IDX_W-1:0]    m_nearest_cluster;
    dist_t                   m_min_distance;

    // Model state: center table and the two count registers.
    coord_t                  centers [MAX_CLUSTERS][MAX_DIMS];
    logic [CLUSTERS_W-1:0]   clusters_reg;
    logic [DIMS_W-1:0]       dims_reg;
    nearest_t                pending_nearest [$];

    // Directed stimulus list.
    stim_row_t               rows [$];

    int n_mismatch = 0;
    int n_loads    = 0;
    int n_points   = 0;
    int n_checked  = 0;
    int n_cfg      = 0;
    int hold_done  = 0;
    bit hold_request = 1'b0;
    bit idle_on      = 1'b1;

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    kmeans_nearest_centroid_top dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_center_slot     (s_center_slot),
        .s_coord_0         (s_coord_0),
        .s_coord_1         (s_coord_1),
        .s_coord_2         (s_coord_2),
        .s_coord_3         (s_coord_3),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_nearest_cluster (m_nearest_cluster),
        .m_min_distance    (m_min_distance)
    );

    // Scan the active centers and keep the closest; a tie goes to the later one.
    function automatic nearest_t nearest_center(centroid_beat_t b);
        int       nc;
        int       nd;
        dist_t    sum;
        dist_t    p;
        dist_t    q;
        dist_t    diff;
        nearest_t best;
        nc = (clusters_reg == 0) ? 1 :
             (clusters_reg > MAX_CLUSTERS) ? MAX_CLUSTERS : int'(clusters_reg);
        nd = (dims_reg == 0) ? 1 : (dims_reg > MAX_DIMS) ? MAX_DIMS : int'(dims_reg);
        best.idx    = '0;
        best.sqdist = '1;
        for (int c = 0; c < nc; c++) begin
            sum = '0;
            for (int d = 0; d < nd; d++) begin
                p    = dist_t'(b.crd[d]) * dist_t'(SCALE);
                q    = dist_t'(centers[c][d]);
                diff = (p > q) ? p - q : q - p;
                sum  += diff * diff;
            end
            if (!(sum > best.sqdist)) begin
                best.sqdist = sum;
                best.idx    = OUT_IDX_W'(c);
            end
        end
        return best;
    endfunction

    // Update the model for a beat the block has taken.
    function automatic void note_beat(centroid_beat_t b, bit fixed, nearest_t answer);
        if (b.action == ACT_LOAD) begin
            for (int d = 0; d < MAX_DIMS; d++)
                centers[b.slot][d] = b.crd[d];
            n_loads++;
        end else begin
            pending_nearest.insert(pending_nearest.size(),
                                   fixed ? answer : nearest_center(b));
            n_points++;
        end
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_stretch();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    // Add a row at the end of the directed list.
    function automatic void append_row(stim_row_t r);
        rows.insert(rows.size(), r);
    endfunction

    function automatic stim_row_t beat_row(logic act, logic [SLOT_W-1:0] slot,
                                           coord_t c0, coord_t c1, coord_t c2, coord_t c3);
        stim_row_t r;
        r.kind        = ROW_BEAT;
        r.beat.action = act;
        r.beat.slot   = slot;
        r.beat.crd[0] = c0;
        r.beat.crd[1] = c1;
        r.beat.crd[2] = c2;
        r.beat.crd[3] = c3;
        r.reg_idx     = '0;
        r.reg_val     = '0;
        r.fixed       = 1'b0;
        r.answer      = '0;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(logic [CFG_INDEX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] val);
        stim_row_t r;
        r.kind    = ROW_CFG;
        r.beat    = '0;
        r.reg_idx = idx;
        r.reg_val = val;
        r.fixed   = 1'b0;
        r.answer  = '0;
        return r;
    endfunction

    // Attach a result that can be written down by hand.
    function automatic stim_row_t known(stim_row_t r, logic [OUT_IDX_W-1:0] idx,
                                        dist_t sqdist_val);
        r.fixed         = 1'b1;
        r.answer.idx    = idx;
        r.answer.sqdist = sqdist_val;
        return r;
    endfunction

    task automatic report_mismatch(string what);
        // Keep the log readable if the block is badly broken.
        if (n_mismatch < MAX_REPORTS)
            $display("MISMATCH at %0t: %s", $time, what);
        n_mismatch++;
    endtask

    // Offer one beat on the input channel; returns at the falling edge after it is taken.
    task automatic send_beat(centroid_beat_t b, bit fixed, nearest_t answer);
        int gap;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? idle_stretch() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= b.action;
        s_center_slot <= b.slot;
        s_coord_0     <= b.crd[0];
        s_coord_1     <= b.crd[1];
        s_coord_2     <= b.crd[2];
        s_coord_3     <= b.crd[3];
        do @(posedge aclk); while (!s_ready);
        note_beat(b, fixed, answer);
        @(negedge aclk);
    endtask

    // Stop offering, wait for every result, then let any load still in flight finish.
    task automatic quiesce();
        s_valid <= 1'b0;
        while (pending_nearest.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_IDX_CLUSTERS)
            clusters_reg = val[CLUSTERS_W-1:0];
        else
            dims_reg = val[DIMS_W-1:0];
        n_cfg++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Result checker: compare each result beat with the oldest prediction.
    always @(posedge aclk) begin
        nearest_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_nearest.size() == 0) begin
                report_mismatch($sformatf("unexpected result: cluster %0d distance %0d",
                                          m_nearest_cluster, m_min_distance));
            end else begin
                want = pending_nearest.pop_front();
                n_checked++;
                if (m_nearest_cluster !== want.idx)
                    report_mismatch($sformatf("nearest_cluster got %0d want %0d",
                                              m_nearest_cluster, want.idx));
                if (m_min_distance !== want.sqdist)
                    report_mismatch($sformatf("min_distance got %0d want %0d",
                                              m_min_distance, want.sqdist));
            end
        end
    end

    // Result channel backpressure, including the one long hold-off.
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done++;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat (idle_stretch()) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Watchdog: give up when no beat moves on any channel for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // Stimulus.
    initial begin
        centroid_beat_t          b;
        logic [CFG_DATA_W-1:0]   nclu_val;
        logic [CFG_DATA_W-1:0]   ndim_val;
        int                      kind;
        int                      mode;
        int                      src;

        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_action      = ACT_LOAD;
        s_center_slot = '0;
        s_coord_0     = '0;
        s_coord_1     = '0;
        s_coord_2     = '0;
        s_coord_3     = '0;
        clusters_reg  = CLUSTERS_W'(2);
        dims_reg      = DIMS_W'(2);

        // Directed list. Reset counts are two clusters and two dimensions.
        append_row(beat_row(ACT_LOAD, 4'd0, '0, '0, '0, '0));
        append_row(beat_row(ACT_LOAD, 4'd1, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        // Point sits on center 0.
        append_row(known(beat_row(ACT_CLASSIFY, 4'd0, '0, '0, '0, '0), 4'd0, 64'd0));
        // Largest point against the zero and full-scale centers.
        append_row(beat_row(ACT_CLASSIFY, 4'd5, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        // Two equal centers: the later index wins the tie.
        append_row(beat_row(ACT_LOAD, 4'd1, '0, '0, '0, '0));
        append_row(known(beat_row(ACT_CLASSIFY, 4'd10, '0, '0, '0, '0), 4'd1, 64'd0));
        // Coordinates past the dimension count do not enter the distance.
        append_row(beat_row(ACT_LOAD, 4'd0, 24'd100, 24'd200, 24'd300, 24'd400));
        append_row(known(beat_row(ACT_CLASSIFY, 4'd15, 24'd1, 24'd2, COORD_MAX, COORD_MAX),
                         4'd0, 64'd0));
        // Fill the rest of the table before more clusters are enabled.
        for (int s = 2; s < MAX_CLUSTERS; s++)
            append_row(beat_row(ACT_LOAD, SLOT_W'(s), coord_t'(s * 1000003),
                                coord_t'(s * 791900), coord_t'((16 - s) * 333333),
                                (s == MAX_CLUSTERS - 1) ? COORD_MAX : coord_t'(s * 100)));
        // Full table, all dimensions.
        append_row(cfg_row(CFG_IDX_CLUSTERS, 8'd16));
        append_row(cfg_row(CFG_IDX_DIMS, 8'd4));
        append_row(beat_row(ACT_CLASSIFY, 4'd3, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        append_row(beat_row(ACT_CLASSIFY, 4'd12, '0, '0, '0, '0));
        // Zero counts behave as one: only center 0 and the first coordinate.
        append_row(cfg_row(CFG_IDX_CLUSTERS, 8'd0));
        append_row(cfg_row(CFG_IDX_DIMS, 8'd0));
        append_row(known(beat_row(ACT_CLASSIFY, 4'd7, 24'd1, COORD_MAX, '0, COORD_MAX),
                         4'd0, 64'd0));
        // Counts above range saturate; upper data bits fall outside the registers.
        append_row(cfg_row(CFG_IDX_CLUSTERS, 8'hFF));
        append_row(cfg_row(CFG_IDX_DIMS, 8'hFF));
        append_row(beat_row(ACT_CLASSIFY, 4'd9, 24'd12345, '0, COORD_MAX, 24'd777));

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                quiesce();
                write_register(rows[i].reg_idx, rows[i].reg_val);
            end else begin
                send_beat(rows[i].beat, rows[i].fixed, rows[i].answer);
            end
        end

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            quiesce();
            case (ph)
                0: begin
                    nclu_val = 8'd16;
                    ndim_val = 8'd4;
                end
                1: begin
                    nclu_val = 8'd1;
                    ndim_val = 8'd1;
                end
                2: begin
                    nclu_val = 8'd16;
                    ndim_val = 8'd4;
                end
                default: begin
                    nclu_val = ($urandom_range(0, 1) == 0) ?
                               CFG_DATA_W'($urandom_range(1, MAX_CLUSTERS)) :
                               CFG_DATA_W'($urandom);
                    ndim_val = CFG_DATA_W'($urandom);
                end
            endcase
            write_register(CFG_IDX_CLUSTERS, nclu_val);
            write_register(CFG_IDX_DIMS, ndim_val);
            // Every fourth phase runs with no idling on either side.
            idle_on = (ph % 4 != 3);
            if (ph == 2)
                hold_request = 1'b1;

            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                kind   = $urandom_range(0, 99);
                mode   = $urandom_range(0, 99);
                src    = $urandom_range(0, MAX_CLUSTERS - 1);
                b.slot = SLOT_W'($urandom_range(0, MAX_CLUSTERS - 1));
                if (kind < 25) begin
                    // New center: full-range, a copy of another (ties), or near a point grid.
                    b.action = ACT_LOAD;
                    for (int d = 0; d < NUM_COORDS; d++) begin
                        if (mode < 40)
                            b.crd[d] = coord_t'($urandom);
                        else if (mode < 65)
                            b.crd[d] = centers[src][d];
                        else
                            b.crd[d] = coord_t'($urandom_range(0, 50000) * 100 +
                                                $urandom_range(0, 3));
                    end
                end else begin
                    // Point: full-range, close to a known center, or at the corners.
                    b.action = ACT_CLASSIFY;
                    for (int d = 0; d < NUM_COORDS; d++) begin
                        if (mode < 35)
                            b.crd[d] = coord_t'($urandom);
                        else if (mode < 85)
                            b.crd[d] = coord_t'(centers[src][d] / 100 + $urandom_range(0, 2));
                        else
                            b.crd[d] = ($urandom_range(0, 1) == 0) ? COORD_MAX : '0;
                    end
                end
                send_beat(b, 1'b0, '0);
            end
        end

        quiesce();
        $display("Covered %0d center loads, %0d points and %0d register writes",
                 n_loads, n_points, n_cfg);
        $display("Checked %0d results with %0d long output hold-off(s); %0d mismatches",
                 n_checked, hold_done, n_mismatch);
        if (n_mismatch == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
